@@ src/tcpaq_pkg.sv @@
// Shared constants and codes for the two-class priority advertising queue.
`default_nettype none

package tcpaq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TAG_BITS    = 16;

  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int LIMIT_W   = 5;
  localparam int FILL_W    = 5;
  localparam int TOTAL_W   = 32;
  localparam int CFG_IDX_W = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // opcodes
  localparam logic [OP_W-1:0] OP_ENQ_ORIG  = 2'd0;
  localparam logic [OP_W-1:0] OP_ENQ_RELAY = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVERTISE = 2'd2;

  // enqueue status codes
  localparam logic [STATUS_W-1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NONE     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIG_LIMIT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_LIMIT = 8'd1;

endpackage

`default_nettype wire

@@ src/tcpaq_ram.sv @@
// Generic single-write, single-read RAM with registered, enabled read.
`default_nettype none

module tcpaq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next enabled read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/two_class_priority_adv_queue.sv @@
// Two-class strict-priority tag queue with tail drop and saturating counters.
// The result word of an accepted input word is registered for the next cycle.
// Throughput: one word per cycle unless a result is held; the served tag RAM's
// registered read port fetches the head tag in the cycle an advertise is taken.
// Reset clears heads, fills and counters and sets both limits to 16;
// tag RAM contents are undefined until written and need no clearing pass.
`default_nettype none

module two_class_priority_adv_queue #(
  parameter int QUEUE_DEPTH = tcpaq_pkg::DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = tcpaq_pkg::DEF_TAG_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tcpaq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tcpaq_pkg::LIMIT_W-1:0]    cfg_data_i,

  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [tcpaq_pkg::OP_W-1:0]       opcode_i,
  input  wire logic [TAG_BITS-1:0]              packet_tag_i,

  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  sent_valid_o,
  output logic      [TAG_BITS-1:0]              sent_tag_o,
  output logic                                  sent_from_relay_o,
  output logic      [tcpaq_pkg::STATUS_W-1:0]   enqueue_status_o,
  output logic      [tcpaq_pkg::TOTAL_W-1:0]    originator_drops_o,
  output logic      [tcpaq_pkg::TOTAL_W-1:0]    relay_drops_o,
  output logic      [tcpaq_pkg::TOTAL_W-1:0]    relays_sent_o,
  output logic      [tcpaq_pkg::FILL_W-1:0]     originator_fill_o,
  output logic      [tcpaq_pkg::FILL_W-1:0]     relay_fill_o
);

  import tcpaq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = ((CNT_W > PTR_W) ? CNT_W : PTR_W) + 1;
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  function automatic logic [PTR_W-1:0] tail_of(logic [PTR_W-1:0] head,
                                                logic [CNT_W-1:0] cnt);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(cnt);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] head_next(logic [PTR_W-1:0] head);
    return (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
  endfunction

  function automatic logic is_full(logic [CNT_W-1:0] cnt, logic [LIMIT_W-1:0] lim);
    return (CMP_W'(cnt) >= CMP_W'(lim)) || (cnt == CNT_W'(QUEUE_DEPTH));
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_inc(logic [TOTAL_W-1:0] v);
    return (&v) ? v : v + TOTAL_W'(1);
  endfunction

  logic [LIMIT_W-1:0]  orig_limit_q, relay_limit_q;
  logic [PTR_W-1:0]    orig_head_q, orig_head_d, relay_head_q, relay_head_d;
  logic [CNT_W-1:0]    orig_cnt_q, orig_cnt_d, relay_cnt_q, relay_cnt_d;
  logic [TOTAL_W-1:0]  orig_drops_q, orig_drops_d, relay_drops_q, relay_drops_d;
  logic [TOTAL_W-1:0]  relays_sent_q, relays_sent_d;
  logic                out_valid_q, out_valid_d;
  logic                sent_valid_q, sent_valid_d;
  logic                from_relay_q, from_relay_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic accept;
  logic is_eo, is_er, is_adv;
  logic orig_full, relay_full;
  logic orig_push, relay_push, orig_pop, relay_pop;
  logic [TAG_BITS-1:0] orig_rdata, relay_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  assign is_eo  = (opcode_i == OP_ENQ_ORIG);
  assign is_er  = (opcode_i == OP_ENQ_RELAY);
  assign is_adv = (opcode_i == OP_ADVERTISE);

  assign orig_full  = is_full(orig_cnt_q, orig_limit_q);
  assign relay_full = is_full(relay_cnt_q, relay_limit_q);

  assign orig_push  = accept && is_eo && !orig_full;
  assign relay_push = accept && is_er && !relay_full;
  // strict priority: relay is served only when the originator queue is empty
  assign orig_pop   = accept && is_adv && (orig_cnt_q != '0);
  assign relay_pop  = accept && is_adv && (orig_cnt_q == '0) && (relay_cnt_q != '0);

  always_comb begin
    orig_head_d   = orig_head_q;
    relay_head_d  = relay_head_q;
    orig_cnt_d    = orig_cnt_q;
    relay_cnt_d   = relay_cnt_q;
    orig_drops_d  = orig_drops_q;
    relay_drops_d = relay_drops_q;
    relays_sent_d = relays_sent_q;
    out_valid_d   = out_valid_q;
    sent_valid_d  = sent_valid_q;
    from_relay_d  = from_relay_q;
    status_d      = status_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      out_valid_d  = 1'b1;
      sent_valid_d = orig_pop || relay_pop;
      from_relay_d = relay_pop;
      status_d     = STAT_NONE;

      if (is_eo) begin
        status_d = orig_full ? STAT_DROPPED : STAT_ACCEPTED;
        if (orig_full) begin
          orig_drops_d = sat_inc(orig_drops_q);
        end
      end
      if (is_er) begin
        status_d = relay_full ? STAT_DROPPED : STAT_ACCEPTED;
        if (relay_full) begin
          relay_drops_d = sat_inc(relay_drops_q);
        end
      end

      if (orig_push) begin
        orig_cnt_d = orig_cnt_q + CNT_W'(1);
      end
      if (relay_push) begin
        relay_cnt_d = relay_cnt_q + CNT_W'(1);
      end
      if (orig_pop) begin
        orig_cnt_d  = orig_cnt_q - CNT_W'(1);
        orig_head_d = head_next(orig_head_q);
      end
      if (relay_pop) begin
        relay_cnt_d   = relay_cnt_q - CNT_W'(1);
        relay_head_d  = head_next(relay_head_q);
        relays_sent_d = sat_inc(relays_sent_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orig_limit_q  <= LIMIT_RESET;
      relay_limit_q <= LIMIT_RESET;
      orig_head_q   <= '0;
      relay_head_q  <= '0;
      orig_cnt_q    <= '0;
      relay_cnt_q   <= '0;
      orig_drops_q  <= '0;
      relay_drops_q <= '0;
      relays_sent_q <= '0;
      out_valid_q   <= 1'b0;
      sent_valid_q  <= 1'b0;
      from_relay_q  <= 1'b0;
      status_q      <= STAT_NONE;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ORIG_LIMIT:  orig_limit_q  <= cfg_data_i;
          CFG_RELAY_LIMIT: relay_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      orig_head_q   <= orig_head_d;
      relay_head_q  <= relay_head_d;
      orig_cnt_q    <= orig_cnt_d;
      relay_cnt_q   <= relay_cnt_d;
      orig_drops_q  <= orig_drops_d;
      relay_drops_q <= relay_drops_d;
      relays_sent_q <= relays_sent_d;
      out_valid_q   <= out_valid_d;
      sent_valid_q  <= sent_valid_d;
      from_relay_q  <= from_relay_d;
      status_q      <= status_d;
    end
  end

  tcpaq_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_orig_ram (
    .clk_i   (clk_i),
    .we_i    (orig_push),
    .waddr_i (tail_of(orig_head_q, orig_cnt_q)),
    .wdata_i (packet_tag_i),
    .re_i    (orig_pop),
    .raddr_i (orig_head_q),
    .rdata_o (orig_rdata)
  );

  tcpaq_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_relay_ram (
    .clk_i   (clk_i),
    .we_i    (relay_push),
    .waddr_i (tail_of(relay_head_q, relay_cnt_q)),
    .wdata_i (packet_tag_i),
    .re_i    (relay_pop),
    .raddr_i (relay_head_q),
    .rdata_o (relay_rdata)
  );

  // counters and fills are the live state: it only moves when a new word is taken
  assign out_valid_o        = out_valid_q;
  assign sent_valid_o       = sent_valid_q;
  assign sent_from_relay_o  = from_relay_q;
  assign sent_tag_o         = !sent_valid_q ? '0 : (from_relay_q ? relay_rdata : orig_rdata);
  assign enqueue_status_o   = status_q;
  assign originator_drops_o = orig_drops_q;
  assign relay_drops_o      = relay_drops_q;
  assign relays_sent_o      = relays_sent_q;
  assign originator_fill_o  = FILL_W'(orig_cnt_q);
  assign relay_fill_o       = FILL_W'(relay_cnt_q);

endmodule

`default_nettype wire

@@ src/tcpaq_checker.sv @@
// Port-level assertions for the queue top level, with the bind that attaches them.
`default_nettype none

module tcpaq_checker #(
  parameter int TAG_BITS = tcpaq_pkg::DEF_TAG_BITS
) (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire logic                             sent_valid_o,
  input wire logic [TAG_BITS-1:0]              sent_tag_o,
  input wire logic                             sent_from_relay_o,
  input wire logic [tcpaq_pkg::STATUS_W-1:0]   enqueue_status_o,
  input wire logic [tcpaq_pkg::TOTAL_W-1:0]    relays_sent_o
);

  import tcpaq_pkg::*;

  // an accepted word always yields a result word in the next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word produced no result");

  // a stalled result word holds
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sent_tag_o)
      && $stable(sent_valid_o) && $stable(enqueue_status_o) && $stable(relays_sent_o))
    else $error("stalled result word changed");

  // nothing sent means tag and source are zero
  a_idle_send_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sent_valid_o |-> sent_tag_o == '0 && !sent_from_relay_o)
    else $error("tag or source set without a send");

  // a send only comes from an advertise, never from an enqueue
  a_send_not_enqueue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sent_valid_o |-> enqueue_status_o == STAT_NONE)
    else $error("send reported alongside an enqueue status");

endmodule

bind two_class_priority_adv_queue tcpaq_checker #(.TAG_BITS(TAG_BITS)) u_tcpaq_checker (.*);

`default_nettype wire
